// ===== rtl/core/dual_water_sensor_confirm_alarm_top_defines.svh =====
// Assertion macros for the water probe alarm block.
`ifndef DUAL_WATER_SENSOR_CONFIRM_ALARM_TOP_DEFINES_SVH
`define DUAL_WATER_SENSOR_CONFIRM_ALARM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DWSCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwsca assertion failed");

// Next-cycle implication, disabled during reset.
`define DWSCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwsca assertion failed");

`endif

// ===== rtl/core/dwsca_pkg.sv =====
// Types and constants shared by the water probe alarm block.
package dwsca_pkg;

    localparam int HOLD_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [HOLD_W-1:0] WET_HOLD_RESET = 16'd1000;
    localparam logic [HOLD_W-1:0] DRY_HOLD_RESET = 16'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WET_HOLD = 2'd0,
        REG_DRY_HOLD = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic probe_a_raw;
        logic probe_b_raw;
    } sample_word_t;

    typedef struct packed {
        logic               probe_a_wet;
        logic               probe_b_wet;
        logic               probe_a_changed;
        logic               probe_b_changed;
        logic               alarm_on;
        logic               alarm_raised;
        logic               alarm_cleared;
        logic [COUNT_W-1:0] alarms_total;
    } status_word_t;

    typedef struct packed {
        logic wet;
        logic changed;
    } probe_stat_t;

    typedef struct packed {
        logic               on;
        logic               raised;
        logic               cleared;
        logic [COUNT_W-1:0] total;
    } alarm_stat_t;

endpackage

// ===== rtl/core/dwsca_probe.sv =====
// Debounce filter for one probe: hold counter and confirmed wet state.
module dwsca_probe
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        raw,
    input  logic [dwsca_pkg::HOLD_W-1:0] wet_hold,
    input  logic [dwsca_pkg::HOLD_W-1:0] dry_hold,
    output dwsca_pkg::probe_stat_t      stat
);
    import dwsca_pkg::*;

    logic              last_reg;
    logic [HOLD_W-1:0] held_reg;
    logic [HOLD_W-1:0] held_next;
    logic              conf_reg;
    logic              conf_next;

    always_comb
    begin
        if (raw != last_reg)
        begin
            held_next = '0;
        end
        else if (held_reg != {HOLD_W{1'b1}})
        begin
            held_next = held_reg + {{(HOLD_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            held_next = held_reg;
        end

        if (!raw && !conf_reg && (held_next >= wet_hold))
        begin
            conf_next = 1'b1;
        end
        else if (raw && conf_reg && (held_next >= dry_hold))
        begin
            conf_next = 1'b0;
        end
        else
        begin
            conf_next = conf_reg;
        end

        stat.wet     = conf_next;
        stat.changed = conf_next != conf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b1;
            held_reg <= '0;
            conf_reg <= 1'b0;
        end
        else if (advance)
        begin
            last_reg <= raw;
            held_reg <= held_next;
            conf_reg <= conf_next;
        end
    end

endmodule

// ===== rtl/core/dwsca_alarm.sv =====
// Alarm state, raise and clear pulses, and saturating raise count.
module dwsca_alarm
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   any_wet,
    output dwsca_pkg::alarm_stat_t stat
);
    import dwsca_pkg::*;

    logic               active_reg;
    logic               active_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               raised;
    logic               cleared;

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        raised      = 1'b0;
        cleared     = 1'b0;
        if (any_wet && !active_reg)
        begin
            active_next = 1'b1;
            raised      = 1'b1;
            if (count_reg != {COUNT_W{1'b1}})
            begin
                count_next = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
            end
        end
        else if (!any_wet && active_reg)
        begin
            active_next = 1'b0;
            cleared     = 1'b1;
        end

        stat.on      = active_next;
        stat.raised  = raised;
        stat.cleared = cleared;
        stat.total   = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/dual_water_sensor_confirm_alarm_top.sv =====
// Top level of the dual water probe confirmation and alarm block.
// Each sample word is one millisecond tick with the raw levels of two probes
// (1 dry, 0 wet) and yields exactly one status word in the next cycle. A new
// sample is taken every cycle; the only stall is a finished word not yet taken
// from the status register, then the sample side waits for status_ready. The
// user writes the hold times through the cfg port (index 0 wet hold, index 1
// dry hold, other indexes ignored) only while idle, unenforced by the block.
`include "dual_water_sensor_confirm_alarm_top_defines.svh"

module dual_water_sensor_confirm_alarm_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  dwsca_pkg::sample_word_t         sample,
    output logic                            status_valid,
    input  logic                            status_ready,
    output dwsca_pkg::status_word_t         status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dwsca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwsca_pkg::HOLD_W-1:0]    cfg_data
);
    import dwsca_pkg::*;

    logic [HOLD_W-1:0] wet_hold_reg;
    logic [HOLD_W-1:0] dry_hold_reg;
    logic              advance;
    probe_stat_t       stat_a;
    probe_stat_t       stat_b;
    alarm_stat_t       stat_alarm;
    status_word_t      status_reg;
    status_word_t      status_next;
    logic              status_valid_reg;

    assign cfg_ready    = 1'b1;
    assign sample_ready = !status_valid_reg || status_ready;
    assign advance      = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_hold_reg <= WET_HOLD_RESET;
            dry_hold_reg <= DRY_HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WET_HOLD: wet_hold_reg <= cfg_data;
                REG_DRY_HOLD: dry_hold_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    dwsca_probe u_probe_a
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .raw      (sample.probe_a_raw),
        .wet_hold (wet_hold_reg),
        .dry_hold (dry_hold_reg),
        .stat     (stat_a)
    );

    dwsca_probe u_probe_b
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .raw      (sample.probe_b_raw),
        .wet_hold (wet_hold_reg),
        .dry_hold (dry_hold_reg),
        .stat     (stat_b)
    );

    dwsca_alarm u_alarm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .any_wet (stat_a.wet || stat_b.wet),
        .stat    (stat_alarm)
    );

    always_comb
    begin
        status_next.probe_a_wet     = stat_a.wet;
        status_next.probe_b_wet     = stat_b.wet;
        status_next.probe_a_changed = stat_a.changed;
        status_next.probe_b_changed = stat_b.changed;
        status_next.alarm_on        = stat_alarm.on;
        status_next.alarm_raised    = stat_alarm.raised;
        status_next.alarm_cleared   = stat_alarm.cleared;
        status_next.alarms_total    = stat_alarm.total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            status_valid_reg <= 1'b1;
        end
        else if (status_ready)
        begin
            status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign status_valid = status_valid_reg;
    assign status       = status_reg;

    `DWSCA_ASSERT_NOW(a_pulse_excl, clk, rst_n, status_valid, !(status.alarm_raised && status.alarm_cleared))
    `DWSCA_ASSERT_NOW(a_alarm_follows, clk, rst_n, status_valid, status.alarm_on == (status.probe_a_wet || status.probe_b_wet))
    `DWSCA_ASSERT_NOW(a_raise_on, clk, rst_n, status_valid && status.alarm_raised, status.alarm_on && (status.alarms_total != '0))
    `DWSCA_ASSERT_NEXT(a_stall_hold, clk, rst_n, status_valid && !status_ready, status_valid && $stable(status))

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the dual water probe alarm: tick stimulus, predicted status words.
module testbench;
    import dwsca_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SAT_TICKS       = 40;
    localparam int RAISE_PAIRS     = 50;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_TICKS     = 175;
    localparam int REPORT_CAP      = 40;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_word_t         sample       = '0;
    logic                 status_valid;
    logic                 status_ready = 1'b0;
    status_word_t         status;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [HOLD_W-1:0]    cfg_data     = '0;

    logic [HOLD_W-1:0]  wet_hold = WET_HOLD_RESET;
    logic [HOLD_W-1:0]  dry_hold = DRY_HOLD_RESET;
    logic               last_level [2] = '{1'b1, 1'b1};
    logic [HOLD_W-1:0]  held_ticks [2] = '{16'd0, 16'd0};
    logic               probe_wet  [2] = '{1'b0, 1'b0};
    logic               alarm_active = 1'b0;
    logic [COUNT_W-1:0] raise_count  = '0;

    sample_word_t tick_queue [$];
    status_word_t status_due [$];
    status_word_t due_word;
    int gap_left     = 0;
    int stall_left   = 0;
    int ready_hold   = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    bit calm         = 1'b0;

    dual_water_sensor_confirm_alarm_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .status_valid (status_valid),
        .status_ready (status_ready),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $time);
    endtask

    task automatic predict_status(input sample_word_t s);
        logic         raw [2];
        logic         chg [2];
        logic         was_wet;
        logic         any_wet;
        status_word_t w;
        raw[0] = s.probe_a_raw;
        raw[1] = s.probe_b_raw;
        for (int p = 0; p < 2; p++)
        begin
            was_wet = probe_wet[p];
            if (raw[p] != last_level[p])
            begin
                last_level[p] = raw[p];
                held_ticks[p] = '0;
            end
            else if (held_ticks[p] != '1)
            begin
                held_ticks[p] = held_ticks[p] + 16'd1;
            end
            if (!raw[p] && !probe_wet[p] && held_ticks[p] >= wet_hold)
                probe_wet[p] = 1'b1;
            else if (raw[p] && probe_wet[p] && held_ticks[p] >= dry_hold)
                probe_wet[p] = 1'b0;
            chg[p] = was_wet != probe_wet[p];
        end
        any_wet = probe_wet[0] | probe_wet[1];
        w = '0;
        if (any_wet && !alarm_active)
        begin
            alarm_active   = 1'b1;
            w.alarm_raised = 1'b1;
            if (raise_count != '1)
                raise_count = raise_count + 16'd1;
        end
        else if (!any_wet && alarm_active)
        begin
            alarm_active    = 1'b0;
            w.alarm_cleared = 1'b1;
        end
        w.probe_a_wet     = probe_wet[0];
        w.probe_b_wet     = probe_wet[1];
        w.probe_a_changed = chg[0];
        w.probe_b_changed = chg[1];
        w.alarm_on        = alarm_active;
        w.alarms_total    = raise_count;
        status_due.push_back(w);
    endtask

    task automatic queue_tick(input logic a_raw, input logic b_raw);
        tick_queue.push_back(sample_word_t'{probe_a_raw: a_raw, probe_b_raw: b_raw});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WET_HOLD)
            wet_hold = val;
        else if (idx == REG_DRY_HOLD)
            dry_hold = val;
    endtask

    task automatic set_holds(input logic [HOLD_W-1:0] wet, input logic [HOLD_W-1:0] dry);
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, HOLD_W'($urandom));
        write_reg(REG_WET_HOLD, wet);
        write_reg(REG_DRY_HOLD, dry);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || sample_valid || status_due.size() != 0);
    endtask

    function automatic logic [HOLD_W-1:0] pick_hold();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return HOLD_W'($urandom);
            default: return HOLD_W'($urandom_range(0, 6));
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            gap_left     <= 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                predict_status(sample);
            if (!sample_valid || sample_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    sample_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0)
                begin
                    sample       <= tick_queue.pop_front();
                    sample_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 11) == 0)
                        gap_left <= $urandom_range(1, 9);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (status_valid && status_ready)
            begin
                if (status_due.size() == 0)
                begin
                    report_mismatch("word with nothing due", status.alarms_total, '0);
                end
                else
                begin
                    due_word = status_due.pop_front();
                    if (status.probe_a_wet != due_word.probe_a_wet)
                        report_mismatch("probe_a_wet", 16'(status.probe_a_wet),
                                        16'(due_word.probe_a_wet));
                    if (status.probe_b_wet != due_word.probe_b_wet)
                        report_mismatch("probe_b_wet", 16'(status.probe_b_wet),
                                        16'(due_word.probe_b_wet));
                    if (status.probe_a_changed != due_word.probe_a_changed)
                        report_mismatch("probe_a_changed", 16'(status.probe_a_changed),
                                        16'(due_word.probe_a_changed));
                    if (status.probe_b_changed != due_word.probe_b_changed)
                        report_mismatch("probe_b_changed", 16'(status.probe_b_changed),
                                        16'(due_word.probe_b_changed));
                    if (status.alarm_on != due_word.alarm_on)
                        report_mismatch("alarm_on", 16'(status.alarm_on),
                                        16'(due_word.alarm_on));
                    if (status.alarm_raised != due_word.alarm_raised)
                        report_mismatch("alarm_raised", 16'(status.alarm_raised),
                                        16'(due_word.alarm_raised));
                    if (status.alarm_cleared != due_word.alarm_cleared)
                        report_mismatch("alarm_cleared", 16'(status.alarm_cleared),
                                        16'(due_word.alarm_cleared));
                    if (status.alarms_total != due_word.alarms_total)
                        report_mismatch("alarms_total", status.alarms_total,
                                        due_word.alarms_total);
                end
            end
            if (ready_hold > 0)
            begin
                ready_hold   = ready_hold - 1;
                status_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                status_ready <= 1'b0;
            end
            else
            begin
                status_ready <= 1'b1;
                if (!calm && $urandom_range(0, 11) == 0)
                    stall_left <= $urandom_range(1, 9);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (status_valid && status_ready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [1:0] wet_pick;
        logic       a_raw;
        logic       b_raw;
        a_raw = 1'b1;
        b_raw = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset hold times: nothing confirms
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        wait_drained();

        // zero hold: confirm on the tick of the change
        set_holds(16'd0, 16'd0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        wait_drained();

        set_holds(16'd2, 16'd1);
        repeat (4) queue_tick(1'b0, 1'b1);
        repeat (3) queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        repeat (3) queue_tick(1'b1, 1'b1);
        wait_drained();

        // longest hold: nothing confirms
        set_holds('1, '1);
        repeat (SAT_TICKS) queue_tick(1'b0, 1'b1);
        repeat (SAT_TICKS) queue_tick(1'b1, 1'b0);
        wait_drained();

        // repeated raises and clears
        set_holds(16'd0, 16'd0);
        repeat (RAISE_PAIRS)
        begin
            wet_pick = 2'($urandom_range(1, 3));
            queue_tick(!wet_pick[1], !wet_pick[0]);
            queue_tick(1'b1, 1'b1);
        end
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_holds(pick_hold(), pick_hold());
            if (ph == 2)
                ready_hold = HOLD_OFF_CYCLES;
            if (ph == RANDOM_PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_TICKS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    if ($urandom_range(0, 5) == 0)
                        a_raw = !a_raw;
                    if ($urandom_range(0, 5) == 0)
                        b_raw = !b_raw;
                    queue_tick(a_raw, b_raw);
                end
            end
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dwsca_pkg.sv
rtl/core/dwsca_probe.sv
rtl/core/dwsca_alarm.sv
rtl/core/dual_water_sensor_confirm_alarm_top.sv
dv/testbench.sv
